// ----- hdl/tmp_pkg.sv -----
// shared types, constants and saturation helper for the trapezoidal motion profile block
package tmp_pkg;

  localparam int QW        = 32;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [30:0] MAX_SPEED_RST  = 31'd65536;
  localparam logic [30:0] ACCEL_RATE_RST = 31'd65536;
  localparam logic [15:0] TIME_STEP_RST  = 16'd656;

  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED,
    CFG_ACCEL_RATE,
    CFG_TIME_STEP
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_WB,
    ST_STOP,
    ST_STOP2,
    ST_DECIDE,
    ST_CLAMP,
    ST_COMMIT,
    ST_OUT
  } state_e;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_VT,
    MS_TT,
    MS_AT,
    MS_DV,
    MS_NP
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     mul;
    logic     wb;
    logic     stop;
    logic     stop2;
    logic     decide;
    logic     clamp;
    logic     commit;
    logic     emit;
    mul_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/tmp_ctrl.sv -----
// sequencer for the motion profile datapath: divider steps, multiplies, update
module tmp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tmp_pkg::status_t status_i,
  output tmp_pkg::cmd_t   cmd_o,
  output logic            in_ready_o
);

  tmp_pkg::state_e   state_q, state_d;
  tmp_pkg::mul_sel_e msel_q, msel_d;
  logic [tmp_pkg::CNT_W-1:0] cnt_q, cnt_d;

  localparam logic [tmp_pkg::CNT_W-1:0] CntLast = tmp_pkg::CNT_W'(tmp_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmp_pkg::ST_IDLE;
      msel_q  <= tmp_pkg::MS_VT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      msel_q  <= msel_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    msel_d  = msel_q;
    cnt_d   = cnt_q;
    case (state_q)
      tmp_pkg::ST_IDLE: begin
        if (status_i.in_valid) begin
          state_d = tmp_pkg::ST_DIV;
          cnt_d   = '0;
        end
      end
      tmp_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = tmp_pkg::ST_MUL;
          msel_d  = tmp_pkg::MS_VT;
        end
      end
      tmp_pkg::ST_MUL: state_d = tmp_pkg::ST_WB;
      tmp_pkg::ST_WB: begin
        case (msel_q)
          tmp_pkg::MS_VT: begin
            msel_d  = tmp_pkg::MS_TT;
            state_d = tmp_pkg::ST_MUL;
          end
          tmp_pkg::MS_TT: begin
            msel_d  = tmp_pkg::MS_AT;
            state_d = tmp_pkg::ST_MUL;
          end
          tmp_pkg::MS_AT: begin
            msel_d  = tmp_pkg::MS_DV;
            state_d = tmp_pkg::ST_MUL;
          end
          tmp_pkg::MS_DV: state_d = tmp_pkg::ST_STOP;
          default:        state_d = tmp_pkg::ST_COMMIT;
        endcase
      end
      tmp_pkg::ST_STOP:   state_d = tmp_pkg::ST_STOP2;
      tmp_pkg::ST_STOP2:  state_d = tmp_pkg::ST_DECIDE;
      tmp_pkg::ST_DECIDE: state_d = tmp_pkg::ST_CLAMP;
      tmp_pkg::ST_CLAMP: begin
        state_d = tmp_pkg::ST_MUL;
        msel_d  = tmp_pkg::MS_NP;
      end
      tmp_pkg::ST_COMMIT: state_d = tmp_pkg::ST_OUT;
      tmp_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          state_d = tmp_pkg::ST_IDLE;
        end
      end
      default: state_d = tmp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = msel_q;
    in_ready_o = 1'b0;
    case (state_q)
      tmp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = status_i.in_valid;
      end
      tmp_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      tmp_pkg::ST_MUL:    cmd_o.mul      = 1'b1;
      tmp_pkg::ST_WB:     cmd_o.wb       = 1'b1;
      tmp_pkg::ST_STOP:   cmd_o.stop     = 1'b1;
      tmp_pkg::ST_STOP2:  cmd_o.stop2    = 1'b1;
      tmp_pkg::ST_DECIDE: cmd_o.decide   = 1'b1;
      tmp_pkg::ST_CLAMP:  cmd_o.clamp    = 1'b1;
      tmp_pkg::ST_COMMIT: cmd_o.commit   = 1'b1;
      tmp_pkg::ST_OUT:    cmd_o.emit     = status_i.out_free;
      default: ;
    endcase
  end

  a_load_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == tmp_pkg::ST_DIV && cnt_q == '0)
    else $error("load did not start the divider");

  a_div_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tmp_pkg::ST_DIV |-> cnt_q <= CntLast)
    else $error("divider step count overran");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == tmp_pkg::ST_IDLE && in_ready_o)
    else $error("emit not followed by idle");

endmodule

// ----- hdl/tmp_dp.sv -----
// datapath: position and velocity state, restoring divider, shared multiplier
module tmp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmp_pkg::cmd_t       cmd_i,
  input  logic signed [31:0]  goal_i,
  input  logic [30:0]         max_speed_i,
  input  logic [30:0]         accel_rate_i,
  input  logic [15:0]         time_step_i,
  output logic signed [31:0]  position_o,
  output logic signed [31:0]  velocity_o,
  output logic                braking_o
);

  logic signed [31:0] pos_q, vel_q;
  logic signed [31:0] goal_q;
  logic               dir_q;
  logic [30:0]        rem_q;
  logic [47:0]        quo_q;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic signed [31:0] vt_q, tt_q, half_q, dv_q, dp_q;
  logic signed [31:0] stop_q, nv_q;
  logic               accel_q;
  logic               brake_q;

  logic [31:0] mag_v, mag_nv;
  logic [30:0] t_w;
  logic [30:0] dvsr;
  logic [31:0] trial;
  logic        ge;
  logic [30:0] rem_d;
  logic [31:0] ma, mb;
  logic        mneg;
  logic [47:0] pmag;
  logic signed [31:0] res;
  logic signed [32:0] gdiff, serr;
  logic signed [33:0] step, lim, nv;

  assign mag_v  = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
  assign mag_nv = nv_q[31] ? 32'(-nv_q) : 32'(nv_q);

  // stop time |v|/accel, saturated to 31 bits
  assign t_w   = (|quo_q[47:31]) ? '1 : quo_q[30:0];
  assign dvsr  = (accel_rate_i == '0) ? 31'd1 : accel_rate_i;
  assign trial = {rem_q, quo_q[47]};
  assign ge    = trial >= {1'b0, dvsr};
  assign rem_d = ge ? 31'(trial - {1'b0, dvsr}) : trial[30:0];

  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (cmd_i.sel)
      tmp_pkg::MS_VT: begin
        ma   = mag_v;
        mb   = {1'b0, t_w};
        mneg = vel_q[31];
      end
      tmp_pkg::MS_TT: begin
        ma = {1'b0, t_w};
        mb = {1'b0, t_w};
      end
      tmp_pkg::MS_AT: begin
        ma = {1'b0, accel_rate_i};
        mb = 32'(tt_q);
      end
      tmp_pkg::MS_DV: begin
        ma = {1'b0, accel_rate_i};
        mb = {16'b0, time_step_i};
      end
      tmp_pkg::MS_NP: begin
        ma   = mag_nv;
        mb   = {16'b0, time_step_i};
        mneg = nv_q[31];
      end
      default: ;
    endcase
  end

  // product >> 16 with sign and saturation
  assign pmag = prod_q[63:16];
  always_comb begin
    if (neg_q) begin
      res = (pmag > 48'h0000_8000_0000) ? 32'sh80000000 : signed'(32'(48'd0 - pmag));
    end else begin
      res = (pmag > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF : signed'(pmag[31:0]);
    end
  end

  assign gdiff = 33'(goal_i) - 33'(pos_q);
  assign serr  = 33'(stop_q) - 33'(goal_q);
  assign lim   = $signed({3'b000, max_speed_i});
  assign step  = (accel_q == dir_q) ? 34'(vel_q) + 34'(dv_q) : 34'(vel_q) - 34'(dv_q);

  always_comb begin
    if (step > lim) begin
      nv = lim;
    end else if (step < -lim) begin
      nv = -lim;
    end else begin
      nv = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vel_q   <= '0;
      brake_q <= 1'b0;
    end else if (cmd_i.commit) begin
      pos_q   <= tmp_pkg::sat34(34'(pos_q) + 34'(dp_q));
      vel_q   <= nv_q;
      brake_q <= !accel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      goal_q <= goal_i;
      dir_q  <= !gdiff[32];
      rem_q  <= '0;
      quo_q  <= {mag_v, 16'b0};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[46:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= ma * mb;
      neg_q  <= mneg;
    end
    if (cmd_i.wb) begin
      case (cmd_i.sel)
        tmp_pkg::MS_VT: vt_q   <= res;
        tmp_pkg::MS_TT: tt_q   <= res;
        tmp_pkg::MS_AT: half_q <= res >>> 1;
        tmp_pkg::MS_DV: dv_q   <= res;
        tmp_pkg::MS_NP: dp_q   <= res;
        default: ;
      endcase
    end
    if (cmd_i.stop) begin
      stop_q <= tmp_pkg::sat34(34'(pos_q) + 34'(vt_q));
    end
    if (cmd_i.stop2) begin
      stop_q <= tmp_pkg::sat34(dir_q ? 34'(stop_q) - 34'(half_q)
                                     : 34'(stop_q) + 34'(half_q));
    end
    if (cmd_i.decide) begin
      accel_q <= dir_q ? serr[32] : (!serr[32] && serr != '0);
    end
    if (cmd_i.clamp) begin
      nv_q <= nv[31:0];
    end
  end

  assign position_o = pos_q;
  assign velocity_o = vel_q;
  assign braking_o  = brake_q;

  a_clamp_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clamp |=> (34'(nv_q) <= lim) && (34'(nv_q) >= -lim))
    else $error("clamped velocity outside speed limit");

  a_tt_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb && cmd_i.sel == tmp_pkg::MS_TT |=> !tt_q[31])
    else $error("t*t came out negative");

endmodule

// ----- hdl/trapezoidal_motion_profile.sv -----
// top level: config registers, controller, datapath and output item register
//
// Trapezoidal motion profile generator, signed Q16.16 throughout.
// Slave stream: one item per motion tick, tdata holds goal_position.
// Master stream: one item per tick, tdata = {command_velocity, command_position},
// tuser = braking (1 when the tick decelerated).
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 max_speed, 1 accel_rate, 2 time_step); write only while idle.
// An accepted item first runs the 48-step restoring divider for the stop time,
// then five passes through one 32x32 multiplier, the last one after the
// stop-point add and saturate steps, the accel or brake decision and the speed
// clamp, and then the commit into position and velocity before the output register.
// tready on the slave side is high only while the block is idle.
// Reset clears position and velocity to zero and loads the register defaults
// (max_speed 1.0, accel_rate 1.0, time_step 656).
// A stalled master side holds the result in the output register; the next
// item is accepted and worked on, and its result waits until the slot frees.
module trapezoidal_motion_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] goal_position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] command_position, [63:32] command_velocity
  output logic        m_axis_tuser,   // [0] braking
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i
);

  logic [30:0] max_speed_q, accel_rate_q;
  logic [15:0] time_step_q;

  tmp_pkg::cmd_t    cmd;
  tmp_pkg::status_t status;
  logic             in_ready;

  logic signed [31:0] position, velocity;
  logic               braking;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q  <= tmp_pkg::MAX_SPEED_RST;
      accel_rate_q <= tmp_pkg::ACCEL_RATE_RST;
      time_step_q  <= tmp_pkg::TIME_STEP_RST;
    end else if (cfg_we_i) begin
      case (tmp_pkg::cfg_idx_e'(cfg_addr_i))
        tmp_pkg::CFG_MAX_SPEED:  max_speed_q  <= cfg_wdata_i;
        tmp_pkg::CFG_ACCEL_RATE: accel_rate_q <= cfg_wdata_i;
        tmp_pkg::CFG_TIME_STEP:  time_step_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign status.in_valid = s_axis_tvalid;
  assign status.out_free = !out_valid_q || m_axis_tready;

  tmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  tmp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .goal_i       (signed'(s_axis_tdata)),
    .max_speed_i  (max_speed_q),
    .accel_rate_i (accel_rate_q),
    .time_step_i  (time_step_q),
    .position_o   (position),
    .velocity_o   (velocity),
    .braking_o    (braking)
  );

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q <= {velocity, position};
      out_user_q <= braking;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
